// ----- hdl/assert_macros.svh -----
// assertion macros used by the table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/stni_pkg.sv -----
// types and constants of the sorted top-n insertion table
`timescale 1ns / 1ps
package stni_pkg;

  localparam int unsigned FILL_BASE      = 50;
  localparam int unsigned FILL_STEP      = 5;
  localparam int unsigned RESET_CAPACITY = 20;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_LOW   = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_SCAN,
    S_PLAN,
    S_SHIFT,
    S_PUT,
    S_READ,
    S_EMIT
  } fsm_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] new_score;
    logic [4:0]  read_index;
  } req_item_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  position;
    logic [15:0] entry_value;
    logic [5:0]  entry_count;
  } rsp_item_t;

  typedef logic [5:0] cfg_item_t;

endpackage

// ----- hdl/stni_if.sv -----
// valid/ready channel carrying one payload item
`timescale 1ns / 1ps
interface stni_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/sorted_top_n_insert_table.sv -----
// sorted top-n score table: search, shift, insert and read over one score memory
//
//   channel  role     payload
//   cfg      sink     capacity_limit (6 bits)
//   req      sink     opcode, new_score, read_index
//   rsp      source   status, position, entry_value, entry_count
//
// insert: S_SCAN searches the count entries and S_PLAN plans, then S_SHIFT moves up to count
//   entries (one read and one write per cycle) and S_PUT writes the score; duplicates
//   and low scores go from S_PLAN straight to S_EMIT.
// read: S_READ, then S_EMIT; a read out of range goes straight to S_EMIT.
// after reset and after each cfg write all DEPTH entries of the memory are refilled,
//   with req.ready low. a rsp still waiting holds the next item in emit.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sorted_top_n_insert_table import stni_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int SCORE_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  stni_if.sink   cfg,
  stni_if.sink   req,
  stni_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RESET_CAP = (RESET_CAPACITY > DEPTH) ? DEPTH : RESET_CAPACITY;

  fsm_t state, state_next;

  logic [CW-1:0]         cap, cnt, cap_lim;
  logic [AW-1:0]         fill_idx;
  logic [SCORE_BITS-1:0] fill_val;
  logic [SCORE_BITS-1:0] score;
  logic [CW-1:0]         scan_idx;
  logic                  pend;
  logic [AW-1:0]         pend_idx;
  logic                  dup;
  logic [AW-1:0]         dup_at;
  logic [CW-1:0]         smaller;
  logic                  up;
  logic [AW-1:0]         src, pend_dst, put_addr;
  logic [CW-1:0]         rem;
  status_t               res_status;
  logic [4:0]            res_pos;
  logic [15:0]           res_value;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [SCORE_BITS-1:0] mem_wdata, mem_rdata;

  logic cfg_fire, req_fire, in_range, full, rsp_load;

  assign cfg_fire = cfg.valid && cfg.ready;
  assign req_fire = req.valid && req.ready;
  assign in_range = 32'(req.data.read_index) < 32'(cnt);
  assign full     = cnt >= cap;
  assign rsp_load = (state == S_EMIT) && (!rsp.valid || rsp.ready) && !cfg_fire;

  always_comb begin
    if (cfg.data == 6'd0) begin
      cap_lim = CW'(1);
    end else if (32'(cfg.data) > DEPTH) begin
      cap_lim = CW'(DEPTH);
    end else begin
      cap_lim = CW'(cfg.data);
    end
  end

  stni_ram #(
    .WIDTH (SCORE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_FILL: begin
        if (fill_idx == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          if (req.data.opcode == OP_READ) begin
            state_next = in_range ? S_READ : S_EMIT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_idx == cnt && !pend) state_next = S_PLAN;
      end
      S_PLAN: begin
        if (dup || (full && smaller == '0)) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (rem == '0 && !pend) state_next = S_PUT;
      end
      S_PUT:  state_next = S_EMIT;
      S_READ: state_next = S_EMIT;
      S_EMIT: begin
        if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (cfg_fire) state_next = S_FILL;
  end

  // handshake and memory control
  always_comb begin
    req.ready = 1'b0;
    cfg.ready = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = fill_idx;
    mem_wdata = fill_val;
    mem_re    = 1'b0;
    mem_raddr = src;
    unique case (state)
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        req.ready = 1'b1;
        mem_re    = req.valid && req.data.opcode == OP_READ;
        mem_raddr = AW'(req.data.read_index);
      end
      S_SCAN: begin
        mem_re    = scan_idx < cnt;
        mem_raddr = scan_idx[AW-1:0];
      end
      S_SHIFT: begin
        mem_re    = rem != '0;
        mem_we    = pend;
        mem_waddr = pend_dst;
        mem_wdata = mem_rdata;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = put_addr;
        mem_wdata = score;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      cap       <= CW'(RESET_CAP);
      cnt       <= CW'(RESET_CAP);
      fill_idx  <= '0;
      fill_val  <= SCORE_BITS'(FILL_BASE);
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (cfg_fire) begin
        cap      <= cap_lim;
        cnt      <= cap_lim;
        fill_idx <= '0;
        fill_val <= SCORE_BITS'(FILL_BASE);
        pend     <= 1'b0;
      end else begin
        case (state)
          S_FILL: begin
            fill_idx <= fill_idx + 1'b1;
            fill_val <= fill_val + SCORE_BITS'(FILL_STEP);
          end
          S_IDLE: begin
            if (req_fire) begin
              score    <= SCORE_BITS'(req.data.new_score);
              scan_idx <= '0;
              pend     <= 1'b0;
              dup      <= 1'b0;
              dup_at   <= '0;
              smaller  <= '0;
              if (req.data.opcode == OP_READ) begin
                res_status <= in_range ? ST_DONE : ST_RANGE;
                res_pos    <= req.data.read_index;
                res_value  <= '0;
              end else begin
                res_status <= ST_DONE;
                res_pos    <= '0;
                res_value  <= 16'(SCORE_BITS'(req.data.new_score));
              end
            end
          end
          S_SCAN: begin
            // the read is issued in the cycle before its compare
            if (scan_idx < cnt) begin
              scan_idx <= scan_idx + 1'b1;
              pend     <= 1'b1;
              pend_idx <= scan_idx[AW-1:0];
            end else begin
              pend <= 1'b0;
            end
            if (pend) begin
              if (mem_rdata == score) begin
                if (!dup) dup_at <= pend_idx;
                dup <= 1'b1;
              end else if (score > mem_rdata) begin
                smaller <= CW'(pend_idx) + 1'b1;
              end
            end
          end
          S_PLAN: begin
            pend <= 1'b0;
            if (dup) begin
              res_status <= ST_DUP;
              res_pos    <= 5'(dup_at);
            end else if (full) begin
              if (smaller == '0) begin
                res_status <= ST_LOW;
                res_pos    <= '0;
              end else begin
                // drop the smallest: slide entries below the slot down by one
                up       <= 1'b1;
                src      <= AW'(1);
                rem      <= smaller - 1'b1;
                put_addr <= AW'(smaller - 1'b1);
                res_pos  <= 5'(smaller - 1'b1);
              end
            end else begin
              // open a slot: move larger entries up, top first
              up       <= 1'b0;
              src      <= AW'(cnt - 1'b1);
              rem      <= cnt - smaller;
              put_addr <= smaller[AW-1:0];
              res_pos  <= 5'(smaller);
              cnt      <= cnt + 1'b1;
            end
          end
          S_SHIFT: begin
            if (rem != '0) begin
              pend     <= 1'b1;
              pend_dst <= up ? src - 1'b1 : src + 1'b1;
              src      <= up ? src + 1'b1 : src - 1'b1;
              rem      <= rem - 1'b1;
            end else begin
              pend <= 1'b0;
            end
          end
          S_READ: begin
            res_value <= 16'(mem_rdata);
          end
          S_EMIT: begin
            if (rsp_load) begin
              rsp.data.status      <= res_status;
              rsp.data.position    <= res_pos;
              rsp.data.entry_value <= res_value;
              rsp.data.entry_count <= 6'(cnt);
            end
          end
          default: begin
            pend <= pend;
          end
        endcase
      end
    end
  end

  `ASSERT_IMPLY(a_cnt_within_cap, clk, rst, 1'b1, cnt <= cap && cap != '0)
  `ASSERT_IMPLY(a_idle_no_write, clk, rst, state == S_IDLE, !mem_we)
  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, req_fire && !cfg_fire, state != S_IDLE)
  `ASSERT_IMPLY(a_shift_dst_in_range, clk, rst, state == S_SHIFT && mem_we, 32'(pend_dst) < 32'(cnt))

endmodule

// ----- hdl/stni_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module stni_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
